[rtl/tfs_pkg.sv]
`default_nettype none
package tfs_pkg;

    // Field widths
    localparam int TYPE_W   = 4;
    localparam int INDEX_W  = 12;
    localparam int DATA_W   = 24;
    localparam int ITEM_W   = 26;
    localparam int TOTAL_W  = 32;

    // Type codes at or above this count look up as zero
    localparam int NUM_TYPES = 16;

    // Default stored energy width
    localparam int ENERGY_BITS_DEF = 24;

    // Table depths (stride of 16 per position)
    localparam int SINGLE_DEPTH = 16;
    localparam int PAIR_DEPTH   = 256;
    localparam int TRIPLE_DEPTH = 4096;

    // Accumulator width: four 24-bit terms plus a 32-bit total, with headroom
    localparam int ACC_W = 35;

    typedef enum logic
    {
        OP_SCORE = 1'b0,
        OP_WRITE = 1'b1
    } opcode_t;

    typedef enum logic [1:0]
    {
        SEL_SINGLE = 2'd0,
        SEL_PAIR   = 2'd1,
        SEL_SKIP   = 2'd2,
        SEL_TRIPLE = 2'd3
    } table_sel_t;

    // Which lookups count for a score beat, plus total clear
    typedef struct packed
    {
        logic single_en;
        logic pair_en;
        logic skip_en;
        logic triple_en;
        logic new_pose;
    } lookup_ctl_t;

endpackage
`default_nettype wire

[rtl/trigram_fragment_score.sv]
`default_nettype none
// Trigram fragment scorer. Score beats (opcode 0) each produce one result beat
// with the fragment's energy (single, adjacent pair, skip pair and triple terms,
// saturated to 26 bits) and the saturating running total; load beats (opcode 1)
// write one table entry and produce no result. One item is accepted per cycle
// while in_ready is high; a score result passes through the registered table
// reads, then the adder tree into the output register.
// A load is visible to a score accepted in the very next cycle. After reset the
// block sweeps all tables to zero, one entry per cycle up to the triple table
// depth, with in_ready held low during that sweep.
module trigram_fragment_score #(
    parameter int ENERGY_BITS = tfs_pkg::ENERGY_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic                               opcode,
    input  wire logic [tfs_pkg::TYPE_W-1:0]         frag_type,
    input  wire logic                               chain_start,
    input  wire logic                               new_pose,
    input  wire logic [1:0]                         table_select,
    input  wire logic [tfs_pkg::INDEX_W-1:0]        table_index,
    input  wire logic signed [tfs_pkg::DATA_W-1:0]  table_value,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed [tfs_pkg::ITEM_W-1:0]       item_energy,
    output logic signed [tfs_pkg::TOTAL_W-1:0]      running_energy
);
    import tfs_pkg::*;

    localparam int SA_W = $clog2(SINGLE_DEPTH);
    localparam int PA_W = $clog2(PAIR_DEPTH);
    localparam int TA_W = $clog2(TRIPLE_DEPTH);
    localparam int WR_W = 33;
    localparam logic signed [WR_W-1:0] E_MAX =
        WR_W'((64'sd1 <<< (ENERGY_BITS - 1)) - 64'sd1);
    localparam logic signed [WR_W-1:0] E_MIN = -E_MAX - WR_W'(1);

    logic            clearing_reg, clearing_next;
    logic [TA_W-1:0] clr_cnt_reg, clr_cnt_next;

    logic            fire;
    logic            score_fire;
    logic            wr_fire;
    logic            load_ok;

    logic signed [WR_W-1:0]  wr_ext;
    logic [ENERGY_BITS-1:0]  wr_sat;
    logic [ENERGY_BITS-1:0]  wr_data;

    logic            single_we, pair_we, skip_we, triple_we;
    logic [SA_W-1:0] single_wa;
    logic [PA_W-1:0] pair_wa;
    logic [TA_W-1:0] triple_wa;

    logic [SA_W-1:0] single_ra;
    logic [PA_W-1:0] pair_ra;
    logic [PA_W-1:0] skip_ra;
    logic [TA_W-1:0] triple_ra;
    lookup_ctl_t     ctl;

    logic [ENERGY_BITS-1:0] single_rd, pair_rd, skip_rd, triple_rd;

    // Input handshake
    assign in_ready   = ~clearing_reg & load_ok;
    assign fire       = in_valid & in_ready;
    assign score_fire = fire & (opcode_t'(opcode) == OP_SCORE);
    assign wr_fire    = fire & (opcode_t'(opcode) == OP_WRITE);

    // Clearing sweep after reset
    always_comb
    begin
        clearing_next = clearing_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (clearing_reg)
        begin
            clr_cnt_next = clr_cnt_reg + TA_W'(1);
            if (clr_cnt_reg == TA_W'(TRIPLE_DEPTH - 1))
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_cnt_reg  <= clr_cnt_next;
        end
    end

    // Load value saturated to the stored width
    always_comb
    begin
        wr_ext = WR_W'(table_value);
        if (wr_ext > E_MAX)
        begin
            wr_sat = E_MAX[ENERGY_BITS-1:0];
        end
        else if (wr_ext < E_MIN)
        begin
            wr_sat = E_MIN[ENERGY_BITS-1:0];
        end
        else
        begin
            wr_sat = wr_ext[ENERGY_BITS-1:0];
        end
        wr_data = clearing_reg ? '0 : wr_sat;
    end

    // Write steering; out-of-range indices are dropped
    always_comb
    begin
        single_we = 1'b0;
        pair_we   = 1'b0;
        skip_we   = 1'b0;
        triple_we = 1'b0;
        if (wr_fire)
        begin
            case (table_sel_t'(table_select))
                SEL_SINGLE: single_we = int'(table_index) < SINGLE_DEPTH;
                SEL_PAIR:   pair_we   = int'(table_index) < PAIR_DEPTH;
                SEL_SKIP:   skip_we   = int'(table_index) < PAIR_DEPTH;
                SEL_TRIPLE: triple_we = 1'b1;
                default:    triple_we = 1'b0;
            endcase
        end
        if (clearing_reg)
        begin
            single_we = 1'b1;
            pair_we   = 1'b1;
            skip_we   = 1'b1;
            triple_we = 1'b1;
        end
        single_wa = clearing_reg ? clr_cnt_reg[SA_W-1:0] : table_index[SA_W-1:0];
        pair_wa   = clearing_reg ? clr_cnt_reg[PA_W-1:0] : table_index[PA_W-1:0];
        triple_wa = clearing_reg ? clr_cnt_reg : table_index[TA_W-1:0];
    end

    tfs_history u_history (
        .clk         (clk),
        .rst_n       (rst_n),
        .score_fire  (score_fire),
        .frag_type   (frag_type),
        .chain_start (chain_start),
        .new_pose    (new_pose),
        .single_addr (single_ra),
        .pair_addr   (pair_ra),
        .skip_addr   (skip_ra),
        .triple_addr (triple_ra),
        .ctl         (ctl)
    );

    tfs_table #(.DEPTH(SINGLE_DEPTH), .WIDTH(ENERGY_BITS)) u_single (
        .clk     (clk),
        .wr_en   (single_we),
        .wr_addr (single_wa),
        .wr_data (wr_data),
        .rd_en   (score_fire),
        .rd_addr (single_ra),
        .rd_data (single_rd)
    );

    tfs_table #(.DEPTH(PAIR_DEPTH), .WIDTH(ENERGY_BITS)) u_pair (
        .clk     (clk),
        .wr_en   (pair_we),
        .wr_addr (pair_wa),
        .wr_data (wr_data),
        .rd_en   (score_fire),
        .rd_addr (pair_ra),
        .rd_data (pair_rd)
    );

    tfs_table #(.DEPTH(PAIR_DEPTH), .WIDTH(ENERGY_BITS)) u_skip (
        .clk     (clk),
        .wr_en   (skip_we),
        .wr_addr (pair_wa),
        .wr_data (wr_data),
        .rd_en   (score_fire),
        .rd_addr (skip_ra),
        .rd_data (skip_rd)
    );

    tfs_table #(.DEPTH(TRIPLE_DEPTH), .WIDTH(ENERGY_BITS)) u_triple (
        .clk     (clk),
        .wr_en   (triple_we),
        .wr_addr (triple_wa),
        .wr_data (wr_data),
        .rd_en   (score_fire),
        .rd_addr (triple_ra),
        .rd_data (triple_rd)
    );

    tfs_accum #(.ENERGY_BITS(ENERGY_BITS)) u_accum (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (score_fire),
        .ctl_in         (ctl),
        .single_data    (single_rd),
        .pair_data      (pair_rd),
        .skip_data      (skip_rd),
        .triple_data    (triple_rd),
        .load_ok        (load_ok),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .item_energy    (item_energy),
        .running_energy (running_energy)
    );

endmodule
`default_nettype wire

[rtl/tfs_table.sv]
`default_nettype none
module tfs_table #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 24,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; holds while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

[rtl/tfs_history.sv]
`default_nettype none
module tfs_history (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               score_fire,
    input  wire logic [tfs_pkg::TYPE_W-1:0]         frag_type,
    input  wire logic                               chain_start,
    input  wire logic                               new_pose,
    output logic [$clog2(tfs_pkg::SINGLE_DEPTH)-1:0] single_addr,
    output logic [$clog2(tfs_pkg::PAIR_DEPTH)-1:0]   pair_addr,
    output logic [$clog2(tfs_pkg::PAIR_DEPTH)-1:0]   skip_addr,
    output logic [$clog2(tfs_pkg::TRIPLE_DEPTH)-1:0] triple_addr,
    output tfs_pkg::lookup_ctl_t                     ctl
);
    import tfs_pkg::*;

    logic [TYPE_W-1:0] prev_type_reg, prev_type_next;
    logic              prev_valid_reg, prev_valid_next;
    logic [TYPE_W-1:0] pp_type_reg, pp_type_next;
    logic              pp_valid_reg, pp_valid_next;

    logic prev_ok_eff;
    logic pp_ok_eff;
    logic ok_c;
    logic ok_p;
    logic ok_pp;

    // Type range checks and chain-start masking of history
    always_comb
    begin
        ok_c        = int'(frag_type) < NUM_TYPES;
        ok_p        = int'(prev_type_reg) < NUM_TYPES;
        ok_pp       = int'(pp_type_reg) < NUM_TYPES;
        prev_ok_eff = prev_valid_reg & ~chain_start;
        pp_ok_eff   = pp_valid_reg & ~chain_start;
    end

    // Lookup addresses: earliest type in the low nibble
    assign single_addr = frag_type;
    assign pair_addr   = {frag_type, prev_type_reg};
    assign skip_addr   = {frag_type, pp_type_reg};
    assign triple_addr = {frag_type, prev_type_reg, pp_type_reg};

    // Term enables
    always_comb
    begin
        ctl.single_en = ok_c;
        ctl.pair_en   = prev_ok_eff & ok_p & ok_c;
        ctl.skip_en   = pp_ok_eff & ok_pp & ok_c;
        ctl.triple_en = pp_ok_eff & ok_pp & ok_c & ok_p;
        ctl.new_pose  = new_pose;
    end

    // History shift on each score beat
    always_comb
    begin
        prev_type_next  = prev_type_reg;
        prev_valid_next = prev_valid_reg;
        pp_type_next    = pp_type_reg;
        pp_valid_next   = pp_valid_reg;
        if (score_fire)
        begin
            pp_type_next    = prev_type_reg;
            pp_valid_next   = prev_ok_eff;
            prev_type_next  = frag_type;
            prev_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_type_reg  <= '0;
            prev_valid_reg <= 1'b0;
            pp_type_reg    <= '0;
            pp_valid_reg   <= 1'b0;
        end
        else
        begin
            prev_type_reg  <= prev_type_next;
            prev_valid_reg <= prev_valid_next;
            pp_type_reg    <= pp_type_next;
            pp_valid_reg   <= pp_valid_next;
        end
    end

endmodule
`default_nettype wire

[rtl/tfs_accum.sv]
`default_nettype none
module tfs_accum #(
    parameter int ENERGY_BITS = tfs_pkg::ENERGY_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                load,
    input  wire tfs_pkg::lookup_ctl_t                ctl_in,
    input  wire logic [ENERGY_BITS-1:0]              single_data,
    input  wire logic [ENERGY_BITS-1:0]              pair_data,
    input  wire logic [ENERGY_BITS-1:0]              skip_data,
    input  wire logic [ENERGY_BITS-1:0]              triple_data,
    output logic                                     load_ok,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [tfs_pkg::ITEM_W-1:0]        item_energy,
    output logic signed [tfs_pkg::TOTAL_W-1:0]       running_energy
);
    import tfs_pkg::*;

    localparam logic signed [ACC_W-1:0] ITEM_MAX  = ACC_W'((64'sd1 <<< (ITEM_W - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] ITEM_MIN  = -ITEM_MAX - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] TOTAL_MAX =
        ACC_W'((64'sd1 <<< (TOTAL_W - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] TOTAL_MIN = -TOTAL_MAX - ACC_W'(1);

    logic                      s1_valid_reg, s1_valid_next;
    lookup_ctl_t               s1_ctl_reg;
    logic                      out_valid_reg, out_valid_next;
    logic signed [ITEM_W-1:0]  item_reg, item_next;
    logic signed [TOTAL_W-1:0] total_reg, total_next;

    logic                      adv;
    logic signed [ACC_W-1:0]   t_single, t_pair, t_skip, t_triple;
    logic signed [ACC_W-1:0]   sum;
    logic signed [ACC_W-1:0]   base;
    logic signed [ACC_W-1:0]   new_total;

    // Handshake between lookup stage and output register
    assign adv     = s1_valid_reg & (~out_valid_reg | out_ready);
    assign load_ok = ~s1_valid_reg | adv;

    // Masked terms, sign extended
    always_comb
    begin
        t_single = s1_ctl_reg.single_en ? ACC_W'($signed(single_data)) : '0;
        t_pair   = s1_ctl_reg.pair_en   ? ACC_W'($signed(pair_data))   : '0;
        t_skip   = s1_ctl_reg.skip_en   ? ACC_W'($signed(skip_data))   : '0;
        t_triple = s1_ctl_reg.triple_en ? ACC_W'($signed(triple_data)) : '0;
        sum      = (t_single + t_pair) + (t_skip + t_triple);
    end

    // Saturating item and running total
    always_comb
    begin
        base      = s1_ctl_reg.new_pose ? '0 : ACC_W'(total_reg);
        new_total = base + sum;
        item_next = item_reg;
        total_next = total_reg;
        if (adv)
        begin
            if (sum > ITEM_MAX)
            begin
                item_next = ITEM_MAX[ITEM_W-1:0];
            end
            else if (sum < ITEM_MIN)
            begin
                item_next = ITEM_MIN[ITEM_W-1:0];
            end
            else
            begin
                item_next = sum[ITEM_W-1:0];
            end

            if (new_total > TOTAL_MAX)
            begin
                total_next = TOTAL_MAX[TOTAL_W-1:0];
            end
            else if (new_total < TOTAL_MIN)
            begin
                total_next = TOTAL_MIN[TOTAL_W-1:0];
            end
            else
            begin
                total_next = new_total[TOTAL_W-1:0];
            end
        end
    end

    // Valid flags
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (load)
        begin
            s1_valid_next = 1'b1;
        end
        else if (adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            total_reg     <= total_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_ctl_reg <= ctl_in;
        end
        item_reg <= item_next;
    end

    assign out_valid      = out_valid_reg;
    assign item_energy    = item_reg;
    assign running_energy = total_reg;

endmodule
`default_nettype wire

[tb/trigram_fragment_score_tb.sv]
`timescale 1ns / 100ps

module trigram_fragment_score_tb;

    import tfs_pkg::*;

    localparam int STORE_BITS   = ENERGY_BITS_DEF;
    localparam int N_RANDOM     = 700;
    localparam int IDLE_LIMIT   = 20000;   // covers the table sweep after reset
    localparam int DRAIN_CYCLES = 8;
    localparam int PRINT_CAP    = 40;

    // One input beat, with an optional hand-written expectation
    typedef struct {
        opcode_t                  op;
        logic [TYPE_W-1:0]        ft;
        logic                     cs;
        logic                     np;
        table_sel_t               sel;
        logic [INDEX_W-1:0]       idx;
        logic signed [DATA_W-1:0] val;
        bit                       has_exp;
        logic signed [ITEM_W-1:0] exp_item;
        logic signed [TOTAL_W-1:0] exp_total;
    } frag_beat_t;

    typedef struct packed {
        logic signed [ITEM_W-1:0]  item;
        logic signed [TOTAL_W-1:0] total;
    } energy_pair_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic                      opcode;
    logic [TYPE_W-1:0]         frag_type;
    logic                      chain_start;
    logic                      new_pose;
    logic [1:0]                table_select;
    logic [INDEX_W-1:0]        table_index;
    logic signed [DATA_W-1:0]  table_value;
    logic                      out_valid;
    logic                      out_ready = 1'b1;
    logic signed [ITEM_W-1:0]  item_energy;
    logic signed [TOTAL_W-1:0] running_energy;

    trigram_fragment_score DUT (.*);

    // Energy tables and scoring history as the block should hold them
    logic signed [STORE_BITS-1:0] single_e [SINGLE_DEPTH];
    logic signed [STORE_BITS-1:0] pair_e   [PAIR_DEPTH];
    logic signed [STORE_BITS-1:0] skip_e   [PAIR_DEPTH];
    logic signed [STORE_BITS-1:0] triple_e [TRIPLE_DEPTH];
    logic [TYPE_W-1:0]            hist_type;
    logic                         hist_valid;
    logic [TYPE_W-1:0]            hist2_type;
    logic                         hist2_valid;
    logic signed [TOTAL_W-1:0]    pose_total;

    energy_pair_t pending_energy [$];
    energy_pair_t want;
    int           mismatches = 0;
    int           idle_cycles = 0;

    // Random segment shape
    int seg_left;
    int seg_lo;
    int seg_span;
    int seg_vmode;
    int seg_write_pct;
    bit seg_calm;

    // Receiver stall state
    int stall_left = 0;
    int calm_left = 0;
    int stall_roll;

    frag_beat_t directed_plan [$];

    function automatic longint clamp_signed(longint v, int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // Table write; returns 0 when the index lies past the table and nothing changes
    function automatic bit store_energy(table_sel_t sel, logic [INDEX_W-1:0] idx,
                                        logic signed [DATA_W-1:0] val);
        longint v;
        bit     stored;
        v = clamp_signed(longint'(val), STORE_BITS);
        stored = 1'b0;
        case (sel)
            SEL_SINGLE:
            begin
                if (idx < SINGLE_DEPTH)
                begin
                    single_e[idx] = v[STORE_BITS-1:0];
                    stored = 1'b1;
                end
            end
            SEL_PAIR:
            begin
                if (idx < PAIR_DEPTH)
                begin
                    pair_e[idx] = v[STORE_BITS-1:0];
                    stored = 1'b1;
                end
            end
            SEL_SKIP:
            begin
                if (idx < PAIR_DEPTH)
                begin
                    skip_e[idx] = v[STORE_BITS-1:0];
                    stored = 1'b1;
                end
            end
            default:
            begin
                triple_e[idx] = v[STORE_BITS-1:0];
                stored = 1'b1;
            end
        endcase
        return stored;
    endfunction

    // Score one fragment. Every 4-bit code lies below the type count, so no
    // lookup reads as zero on account of an out-of-range type.
    function automatic energy_pair_t score_fragment(logic [TYPE_W-1:0] ft, logic cs, logic np);
        longint       sum;
        longint       tot;
        energy_pair_t e;
        if (cs)
        begin
            hist_valid  = 1'b0;
            hist2_valid = 1'b0;
        end
        if (np)
            pose_total = '0;
        sum = longint'(single_e[ft]);
        // index: earliest type in the low nibble
        if (hist_valid)
            sum += longint'(pair_e[{ft, hist_type}]);
        if (hist2_valid)
        begin
            sum += longint'(skip_e[{ft, hist2_type}]);
            sum += longint'(triple_e[{ft, hist_type, hist2_type}]);
        end
        // total takes the unclamped item sum
        tot = clamp_signed(longint'(pose_total) + sum, TOTAL_W);
        pose_total = tot[TOTAL_W-1:0];
        sum = clamp_signed(sum, ITEM_W);
        e.item  = sum[ITEM_W-1:0];
        e.total = pose_total;
        hist2_type  = hist_type;
        hist2_valid = hist_valid;
        hist_type   = ft;
        hist_valid  = 1'b1;
        return e;
    endfunction

    task automatic note_mismatch(input string what, input longint got, input longint exp_v);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("mismatch at %0t: %s got %0d, want %0d", $realtime, what, got, exp_v);
    endtask

    // All-zero score beat to start a table row from
    function automatic frag_beat_t blank_row();
        frag_beat_t b;
        b.op        = OP_SCORE;
        b.ft        = '0;
        b.cs        = 1'b0;
        b.np        = 1'b0;
        b.sel       = SEL_SINGLE;
        b.idx       = '0;
        b.val       = '0;
        b.has_exp   = 1'b0;
        b.exp_item  = '0;
        b.exp_total = '0;
        return b;
    endfunction

    function automatic frag_beat_t load_row(table_sel_t sel, int idx, int val);
        frag_beat_t b;
        b = blank_row();
        b.op  = OP_WRITE;
        b.sel = sel;
        b.idx = idx[INDEX_W-1:0];
        b.val = val[DATA_W-1:0];
        return b;
    endfunction

    function automatic frag_beat_t score_row(int ft, bit cs, bit np);
        frag_beat_t b;
        b = blank_row();
        b.op = OP_SCORE;
        b.ft = ft[TYPE_W-1:0];
        b.cs = cs;
        b.np = np;
        return b;
    endfunction

    function automatic frag_beat_t score_known(int ft, bit cs, bit np, int e_item, int e_total);
        frag_beat_t b;
        b = score_row(ft, cs, np);
        b.has_exp   = 1'b1;
        b.exp_item  = e_item[ITEM_W-1:0];
        b.exp_total = e_total;
        return b;
    endfunction

    function automatic logic [TYPE_W-1:0] draw_type();
        int t;
        t = seg_lo + $urandom_range(0, seg_span - 1);
        return t[TYPE_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] draw_value();
        logic [DATA_W-1:0] v;
        case (seg_vmode)
            0: v = DATA_W'($urandom_range(0, 24'hFFFFFF));
            1:
            begin
                case ($urandom_range(0, 3))
                    0: v = 24'h7FFFFF;
                    1: v = 24'h800000;
                    2: v = 24'h000000;
                    default: v = 24'hFFFFFF;
                endcase
            end
            2: v = 24'h7FFFFF - DATA_W'($urandom_range(0, 255));
            default: v = 24'h800000 + DATA_W'($urandom_range(0, 255));
        endcase
        return v;
    endfunction

    task automatic new_segment();
        seg_left      = $urandom_range(10, 120);
        seg_lo        = $urandom_range(0, 15);
        seg_span      = 1 << (2 * $urandom_range(0, 2));
        if ($urandom_range(0, 3) == 0)
            seg_span = 16;
        seg_vmode     = $urandom_range(0, 3);
        seg_write_pct = $urandom_range(10, 40);
        seg_calm      = ($urandom_range(0, 5) == 0);
    endtask

    // Mostly hits on bins built from the segment's type pool; some raw indices
    function automatic frag_beat_t next_random_beat();
        frag_beat_t        b;
        logic [TYPE_W-1:0] t0;
        logic [TYPE_W-1:0] t1;
        logic [TYPE_W-1:0] t2;
        b.op  = ($urandom_range(0, 99) < seg_write_pct) ? OP_WRITE : OP_SCORE;
        b.ft  = draw_type();
        b.cs  = ($urandom_range(0, 15) == 0);
        // heavy segments keep the total running toward saturation
        b.np  = (seg_vmode >= 2) ? 1'b0 : ($urandom_range(0, 23) == 0);
        b.sel = table_sel_t'($urandom_range(0, 3));
        t0 = draw_type();
        t1 = draw_type();
        t2 = draw_type();
        if ($urandom_range(0, 4) == 0)
            b.idx = INDEX_W'($urandom_range(0, 4095));
        else
        begin
            case (b.sel)
                SEL_SINGLE: b.idx = {8'h00, t0};
                SEL_PAIR, SEL_SKIP: b.idx = {4'h0, t1, t0};
                default: b.idx = {t2, t1, t0};
            endcase
        end
        b.val       = draw_value();
        b.has_exp   = 1'b0;
        b.exp_item  = '0;
        b.exp_total = '0;
        return b;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Drive one beat and hold it until taken; counted is 0 for a write the block ignores
    task automatic send_beat(input frag_beat_t b, output bit counted);
        energy_pair_t e;
        in_valid     <= 1'b1;
        opcode       <= b.op;
        frag_type    <= b.ft;
        chain_start  <= b.cs;
        new_pose     <= b.np;
        table_select <= b.sel;
        table_index  <= b.idx;
        table_value  <= b.val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (b.op == OP_WRITE)
            counted = store_energy(b.sel, b.idx, b.val);
        else
        begin
            e = score_fragment(b.ft, b.cs, b.np);
            if (b.has_exp)
            begin
                e.item  = b.exp_item;
                e.total = b.exp_total;
            end
            pending_energy.insert(pending_energy.size(), e);
            counted = 1'b1;
        end
    endtask

    task automatic rest_sender(input int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Receiver: short stalls, a few long ones, and stall-free stretches
    always @(posedge clk)
    begin
        if (calm_left > 0)
        begin
            calm_left--;
            out_ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 3)
                calm_left = $urandom_range(50, 200);
            else if (stall_roll < 6)
                stall_left = $urandom_range(10, 40);
            else if (stall_roll < 30)
                stall_left = $urandom_range(1, 3);
        end
    end

    // Result check against the oldest pending expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_energy.size() == 0)
                note_mismatch("result beat with nothing pending", item_energy, 0);
            else
            begin
                want = pending_energy.pop_front();
                if (item_energy !== want.item)
                    note_mismatch("item_energy", item_energy, want.item);
                if (running_energy !== want.total)
                    note_mismatch("running_energy", running_energy, want.total);
            end
        end
    end

    // Watchdog on cycles with no beat taken on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[trigram_fragment_score] ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Stimulus
    initial
    begin
        frag_beat_t b;
        bit         counted;
        int         rand_done;
        bit         pressure_done;

        hist_type    = '0;
        hist_valid   = 1'b0;
        hist2_type   = '0;
        hist2_valid  = 1'b0;
        pose_total   = '0;
        foreach (single_e[i]) single_e[i] = '0;
        foreach (pair_e[i])   pair_e[i]   = '0;
        foreach (skip_e[i])   skip_e[i]   = '0;
        foreach (triple_e[i]) triple_e[i] = '0;

        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        opcode       <= OP_SCORE;
        frag_type    <= '0;
        chain_start  <= 1'b0;
        new_pose     <= 1'b0;
        table_select <= SEL_SINGLE;
        table_index  <= '0;
        table_value  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty tables, extremes, ignored writes, full trigram history
        directed_plan.insert(directed_plan.size(), score_known(0, 1, 1, 0, 0));
        directed_plan.insert(directed_plan.size(), score_known(15, 0, 0, 0, 0));
        directed_plan.insert(directed_plan.size(), load_row(SEL_SINGLE, 0, 24'h7FFFFF));
        directed_plan.insert(directed_plan.size(), load_row(SEL_SINGLE, 15, -8388608));
        directed_plan.insert(directed_plan.size(), score_known(0, 1, 1, 8388607, 8388607));
        directed_plan.insert(directed_plan.size(),
                             score_known(15, 1, 1, -8388608, -8388608));
        directed_plan.insert(directed_plan.size(), load_row(SEL_SINGLE, 16, 1));
        directed_plan.insert(directed_plan.size(), load_row(SEL_PAIR, 256, 5));
        directed_plan.insert(directed_plan.size(), load_row(SEL_SKIP, 4095, 7));
        directed_plan.insert(directed_plan.size(), score_known(0, 1, 1, 8388607, 8388607));
        directed_plan.insert(directed_plan.size(), score_known(0, 0, 0, 8388607, 16777214));
        directed_plan.insert(directed_plan.size(), load_row(SEL_PAIR, 12'h0F0, 24'h7FFFFF));
        directed_plan.insert(directed_plan.size(), load_row(SEL_SKIP, 12'h0F0, 24'h7FFFFF));
        directed_plan.insert(directed_plan.size(), load_row(SEL_TRIPLE, 12'hFF0, 24'h7FFFFF));
        directed_plan.insert(directed_plan.size(), load_row(SEL_TRIPLE, 12'hF00, 24'h7FFFFF));
        directed_plan.insert(directed_plan.size(), load_row(SEL_PAIR, 12'h0FF, 24'h7FFFFF));
        directed_plan.insert(directed_plan.size(), load_row(SEL_SKIP, 12'h0FF, -1));
        directed_plan.insert(directed_plan.size(), score_row(0, 1, 1));
        directed_plan.insert(directed_plan.size(), score_row(0, 0, 0));
        directed_plan.insert(directed_plan.size(), score_row(15, 0, 0));
        directed_plan.insert(directed_plan.size(), score_row(15, 0, 0));
        directed_plan.insert(directed_plan.size(), score_row(15, 0, 1));
        directed_plan.insert(directed_plan.size(), score_row(15, 1, 0));
        directed_plan.insert(directed_plan.size(), load_row(SEL_TRIPLE, 0, 24'h123456));
        directed_plan.insert(directed_plan.size(), score_row(0, 0, 0));

        foreach (directed_plan[i])
        begin
            send_beat(directed_plan[i], counted);
            rest_sender(pick_gap());
        end

        // Random: first segment drives the total into positive saturation
        seg_left      = 120;
        seg_lo        = $urandom_range(0, 15);
        seg_span      = 1;
        seg_vmode     = 2;
        seg_write_pct = 20;
        seg_calm      = 1'b0;
        rand_done     = 0;
        pressure_done = 1'b0;
        while (rand_done < N_RANDOM)
        begin
            if (seg_left == 0)
                new_segment();
            seg_left--;
            b = next_random_beat();
            send_beat(b, counted);
            if (counted)
                rand_done++;
            if (!pressure_done && rand_done >= N_RANDOM / 2)
            begin
                // hold off until every result is back
                in_valid <= 1'b0;
                while (pending_energy.size() != 0)
                    @(posedge clk);
                repeat (4) @(posedge clk);
                pressure_done = 1'b1;
            end
            else
                rest_sender(seg_calm ? 0 : pick_gap());
        end

        // Drain
        in_valid <= 1'b0;
        while (pending_energy.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("[trigram_fragment_score] OK");
        else
            $display("[trigram_fragment_score] ERROR");
        $finish;
    end

endmodule
